### hw/rtl/rhc_pkg.sv
// Shared types and constants for the range histogram counter.
// Payload structs, status codes, command codes and store sizing.
// No dependencies.
package rhc_pkg;

  localparam int NUM_BINS    = 256;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam int VALUE_W   = 16;
  localparam int OUT_CNT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = CFG_IDX_W'(1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [OUT_CNT_W-1:0]   bin_count;
  } out_item_t;

endpackage

### hw/rtl/range_histogram_counter_core.sv
// Range histogram counter: bin store with read-modify-write per sample.
// A sample's bin is read into a register on its transfer; the next sample is
// taken only after the write-back, which waits until the output can take it.
// Reset: range_min = 0, range_max = 255, all bins read as zero via per-bin
// valid flops cleared at once; no clearing pass. Uses rhc_pkg.
module range_histogram_counter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rhc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rhc_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rhc_pkg::VALUE_W-1:0]    cfg_data
);
  import rhc_pkg::*;

  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_valid;

  logic signed [VALUE_W-1:0] range_min;
  logic signed [VALUE_W-1:0] range_max;

  state_t state, state_next;
  logic   in_xfer;
  logic   rmw_go;

  logic signed [VALUE_W:0]  offset;
  logic                     in_hit;
  logic [IDX_W-1:0]         in_idx;

  logic                     item_hit;
  logic                     item_cmd;
  logic [IDX_W-1:0]         item_idx;
  logic [COUNT_WIDTH-1:0]   rd_data;
  logic                     rd_valid;

  logic [COUNT_WIDTH-1:0]   cur_cnt;
  logic [COUNT_WIDTH-1:0]   new_cnt;
  status_t                  new_status;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  // Offset from range_min; non-negative whenever the value is in range
  assign offset = $signed({in_data.sample_value[VALUE_W-1], in_data.sample_value})
                - $signed({range_min[VALUE_W-1], range_min});
  assign in_hit = (in_data.sample_value >= range_min)
               && (in_data.sample_value <= range_max)
               && ({1'b0, offset} < (VALUE_W+2)'(NUM_BINS));
  assign in_idx = offset[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= '0;
      range_max <= VALUE_W'(255);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RANGE_MIN: range_min <= cfg_data;
        CFG_RANGE_MAX: range_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_xfer) state_next = S_LOOKUP;
      S_LOOKUP: if (rmw_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rmw_go   = 1'b0;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_LOOKUP: rmw_go   = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Capture the item and read its bin on the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_hit <= in_hit;
      item_cmd <= in_data.command;
      item_idx <= in_idx;
      rd_data  <= bin_mem[in_idx];
      rd_valid <= bin_valid[in_idx];
    end
  end

  assign cur_cnt = rd_valid ? rd_data : '0;

  always_comb begin
    new_cnt    = cur_cnt;
    new_status = ST_OK;
    if (!item_hit) begin
      new_cnt    = '0;
      new_status = ST_RANGE;
    end else if (item_cmd == CMD_REMOVE) begin
      if (cur_cnt == '0) begin
        new_status = ST_ABSENT;
      end else begin
        new_cnt = cur_cnt - COUNT_WIDTH'(1);
      end
    end else if (cur_cnt == COUNT_MAX) begin
      new_status = ST_SAT;
    end else begin
      new_cnt = cur_cnt + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rmw_go && item_hit) begin
      bin_mem[item_idx] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (rmw_go && item_hit) begin
      bin_valid[item_idx] <= 1'b1;
    end
  end

  // Output register: the result waits here while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rmw_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rmw_go) begin
      out_data.status    <= new_status;
      out_data.bin_count <= OUT_CNT_W'(new_cnt);
    end
  end

endmodule
